// ===== src/elevator_two_queue_scheduler_core_macros.svh =====
// assertion macros for the elevator two-queue scheduler
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef ELEVATOR_TWO_QUEUE_SCHEDULER_CORE_MACROS_SVH
`define ELEVATOR_TWO_QUEUE_SCHEDULER_CORE_MACROS_SVH

// checked on every edge outside reset
`define ETS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge, reset included
`define ETS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/ets_pkg.sv =====
// types and codes of the elevator two-queue scheduler
// no dependencies
package ets_pkg;

  localparam int FloorW = 6;

  localparam logic [1:0] CMD_UP   = 2'd0;
  localparam logic [1:0] CMD_DOWN = 2'd1;
  localparam logic [1:0] CMD_RUN  = 2'd2;

  localparam logic [1:0] RES_QUEUED  = 2'd0;
  localparam logic [1:0] RES_DROPPED = 2'd1;
  localparam logic [1:0] RES_STOP    = 2'd2;
  localparam logic [1:0] RES_DONE    = 2'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [FloorW-1:0] from_floor;
    logic [FloorW-1:0] to_floor;
    logic              outside;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [FloorW-1:0] floor;
    logic              down_pass;
    logic              last;
  } res_t;

  typedef enum logic [2:0] {
    IDLE,
    INSERT,
    INSERT_RD,
    RUN_UP,
    RUN_DOWN,
    RUN_END
  } state_e;

endpackage

// ===== src/elevator_two_queue_scheduler_core.sv =====
// elevator two-queue stop scheduler, top level
// depends on ets_pkg and elevator_two_queue_scheduler_core_macros.svh
//
// usage:
//   a request is taken at a clock edge with start high and busy low; req_i carries
//   cmd (up, down, run), the pickup floor, the destination floor and the hall flag
//   results appear on res_o for exactly one cycle with res_valid_o high; the
//   receiver cannot stall, so every result must be taken in that cycle
//   cfg_we_i writes the start floor; the car moves there at once
// timing:
//   up/down request: idle fetches the top queue entry, INSERT moves each larger entry
//   up one slot, then writes the floor; a hall call adds a second insert after INSERT_RD
//   a dropped request gives its result in the next cycle without leaving idle
//   run: one stop per cycle from the shared queue memory read port, up queue
//   ascending then down queue descending, closed by a done result at the car floor
//   the insertion rate is set by the one read port and one write port of the queue memory
//   and the one compare unit that walks it, one entry a cycle
// reset:
//   both queues empty, car at floor 0, sequencer idle; no memory clearing pass
module elevator_two_queue_scheduler_core #(
  parameter int FLOORS      = 64,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  input  ets_pkg::req_t                  req_i,
  output logic                           busy,
  output logic                           res_valid_o,
  output ets_pkg::res_t                  res_o,
  input  logic                           cfg_we_i,
  input  logic [ets_pkg::FloorW-1:0]     cfg_data_i
);

  import ets_pkg::*;

  localparam int IdxW     = $clog2(QUEUE_DEPTH);
  localparam int CntW     = $clog2(QUEUE_DEPTH + 1);
  localparam int AddrW    = IdxW + 1;
  localparam int MemDepth = 2 ** AddrW;

  // saturate a floor number to the top floor
  function automatic logic [FloorW-1:0] clamp_floor(input logic [FloorW-1:0] v);
    if (int'(v) >= FLOORS) begin
      clamp_floor = FloorW'(FLOORS - 1);
    end else begin
      clamp_floor = v;
    end
  endfunction

  // sequencer and datapath registers
  state_e            state_q, state_d;
  logic              sel_q, sel_d;        // 0: up queue, 1: down queue
  logic              hall_q, hall_d;      // destination insert still pending
  logic [FloorW-1:0] val_q, val_d;        // floor being inserted
  logic [FloorW-1:0] to_q, to_d;          // destination floor of the request
  logic [CntW-1:0]   pos_q, pos_d;        // insert slot or run index
  logic [CntW-1:0]   up_cnt_q, up_cnt_d;
  logic [CntW-1:0]   dn_cnt_q, dn_cnt_d;
  logic [FloorW-1:0] car_q, car_d;
  logic              res_valid_q, res_valid_d;
  res_t              res_q, res_d;

  // queue memory: both queues share it, the queue select is the top address bit
  logic [FloorW-1:0] queue_mem [MemDepth];
  logic [FloorW-1:0] rd_data_q;
  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_waddr, mem_raddr;
  logic [FloorW-1:0] mem_wdata;

  // request decode
  logic [FloorW-1:0] from_c, to_c;
  logic              req_sel;
  logic [CntW-1:0]   req_cnt, req_cnt_m1;
  logic [CntW:0]     need_sum;
  logic [CntW-1:0]   cur_cnt, cur_cnt_p1;
  logic [CntW-1:0]   pos_m1, pos_m2, pos_p1;
  logic [CntW-1:0]   dn_cnt_m1;
  logic              shift;

  assign from_c     = clamp_floor(req_i.from_floor);
  assign to_c       = clamp_floor(req_i.to_floor);
  assign req_sel    = (req_i.cmd == CMD_DOWN);
  assign req_cnt    = req_sel ? dn_cnt_q : up_cnt_q;
  assign req_cnt_m1 = req_cnt - CntW'(1);
  // hall calls need two free slots
  assign need_sum   = {1'b0, req_cnt} + (req_i.outside ? (CntW+1)'(2) : (CntW+1)'(1));
  assign cur_cnt    = sel_q ? dn_cnt_q : up_cnt_q;
  assign cur_cnt_p1 = cur_cnt + CntW'(1);
  assign pos_m1     = pos_q - CntW'(1);
  assign pos_m2     = pos_q - CntW'(2);
  assign pos_p1     = pos_q + CntW'(1);
  assign dn_cnt_m1  = dn_cnt_q - CntW'(1);

  // the one compare unit: does the entry below the slot move up
  assign shift = (pos_q != '0) && (rd_data_q > val_q);

  assign busy        = (state_q != IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      queue_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= queue_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      sel_q       <= 1'b0;
      hall_q      <= 1'b0;
      pos_q       <= '0;
      up_cnt_q    <= '0;
      dn_cnt_q    <= '0;
      car_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      hall_q      <= hall_d;
      pos_q       <= pos_d;
      up_cnt_q    <= up_cnt_d;
      dn_cnt_q    <= dn_cnt_d;
      car_q       <= car_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    to_q  <= to_d;
    res_q <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    hall_d      = hall_q;
    val_d       = val_q;
    to_d        = to_q;
    pos_d       = pos_q;
    up_cnt_d    = up_cnt_q;
    dn_cnt_d    = dn_cnt_q;
    car_d       = car_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    // start floor write; the user must write it only while idle, the core does not enforce it
    if (cfg_we_i) begin
      car_d = clamp_floor(cfg_data_i);
    end

    case (state_q)
      IDLE: begin
        if (start) begin
          case (req_i.cmd)
            CMD_UP, CMD_DOWN: begin
              if (need_sum > (CntW+1)'(QUEUE_DEPTH)) begin
                // no room for the whole request
                res_valid_d = 1'b1;
                res_d       = '{status: RES_DROPPED, floor: to_c, down_pass: 1'b0,
                                last: 1'b1};
              end else begin
                sel_d     = req_sel;
                hall_d    = req_i.outside;
                to_d      = to_c;
                val_d     = req_i.outside ? from_c : to_c;
                pos_d     = req_cnt;
                // fetch the current top entry for the first compare
                mem_re    = 1'b1;
                mem_raddr = {req_sel, req_cnt_m1[IdxW-1:0]};
                state_d   = INSERT;
              end
            end
            CMD_RUN: begin
              if (up_cnt_q != '0) begin
                mem_re    = 1'b1;
                mem_raddr = {1'b0, {IdxW{1'b0}}};
                pos_d     = '0;
                state_d   = RUN_UP;
              end else if (dn_cnt_q != '0) begin
                mem_re    = 1'b1;
                mem_raddr = {1'b1, dn_cnt_m1[IdxW-1:0]};
                pos_d     = dn_cnt_m1;
                state_d   = RUN_DOWN;
              end else begin
                state_d = RUN_END;
              end
            end
            default: begin
              // unused command, no result
            end
          endcase
        end
      end

      INSERT: begin
        if (shift) begin
          // move the larger entry up one slot, fetch the next one down
          mem_we    = 1'b1;
          mem_waddr = {sel_q, pos_q[IdxW-1:0]};
          mem_wdata = rd_data_q;
          mem_re    = 1'b1;
          mem_raddr = {sel_q, pos_m2[IdxW-1:0]};
          pos_d     = pos_m1;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = {sel_q, pos_q[IdxW-1:0]};
          mem_wdata = val_q;
          if (sel_q) begin
            dn_cnt_d = cur_cnt_p1;
          end else begin
            up_cnt_d = cur_cnt_p1;
          end
          if (hall_q) begin
            // pickup floor placed, now the destination
            hall_d  = 1'b0;
            val_d   = to_q;
            pos_d   = cur_cnt_p1;
            state_d = INSERT_RD;
          end else begin
            res_valid_d = 1'b1;
            res_d       = '{status: RES_QUEUED, floor: to_q, down_pass: 1'b0,
                            last: 1'b1};
            state_d     = IDLE;
          end
        end
      end

      INSERT_RD: begin
        // separate read cycle, the slot just written may be the one read
        mem_re    = 1'b1;
        mem_raddr = {sel_q, pos_m1[IdxW-1:0]};
        state_d   = INSERT;
      end

      RUN_UP: begin
        res_valid_d = 1'b1;
        res_d       = '{status: RES_STOP, floor: rd_data_q, down_pass: 1'b0,
                        last: 1'b0};
        car_d       = rd_data_q;
        if (pos_p1 != up_cnt_q) begin
          mem_re    = 1'b1;
          mem_raddr = {1'b0, pos_p1[IdxW-1:0]};
          pos_d     = pos_p1;
        end else begin
          up_cnt_d = '0;
          if (dn_cnt_q != '0) begin
            mem_re    = 1'b1;
            mem_raddr = {1'b1, dn_cnt_m1[IdxW-1:0]};
            pos_d     = dn_cnt_m1;
            state_d   = RUN_DOWN;
          end else begin
            state_d = RUN_END;
          end
        end
      end

      RUN_DOWN: begin
        res_valid_d = 1'b1;
        res_d       = '{status: RES_STOP, floor: rd_data_q, down_pass: 1'b1,
                        last: 1'b0};
        car_d       = rd_data_q;
        if (pos_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = {1'b1, pos_m1[IdxW-1:0]};
          pos_d     = pos_m1;
        end else begin
          dn_cnt_d = '0;
          state_d  = RUN_END;
        end
      end

      RUN_END: begin
        res_valid_d = 1'b1;
        res_d       = '{status: RES_DONE, floor: car_q, down_pass: 1'b0, last: 1'b1};
        state_d     = IDLE;
      end

      default: begin
        state_d = IDLE;
      end
    endcase
  end

`include "elevator_two_queue_scheduler_core_macros.svh"

  `ETS_ASSERT(a_cnt_bound, (up_cnt_q <= CntW'(QUEUE_DEPTH)) && (dn_cnt_q <= CntW'(QUEUE_DEPTH)), "queue count beyond depth")
  `ETS_ASSERT(a_done_empty, (res_valid_q && (res_q.status == RES_DONE)) |-> ((up_cnt_q == '0) && (dn_cnt_q == '0)), "run finished with stops left")
  `ETS_ASSERT(a_stop_in_run, (res_valid_q && (res_q.status == RES_STOP)) |-> ((state_q == RUN_UP) || (state_q == RUN_DOWN) || (state_q == RUN_END)), "stop outside a run")
  `ETS_ASSERT(a_req_last, (res_valid_q && ((res_q.status == RES_QUEUED) || (res_q.status == RES_DROPPED))) |-> (res_q.last && (state_q == IDLE)), "request result not final")
  `ETS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> (!res_valid_o && !busy), "activity during reset")

endmodule

// ===== verif/elevator_two_queue_scheduler_core_tb.sv =====
// testbench for elevator_two_queue_scheduler_core: a table of directed requests, then random
// bursts of floor calls closed by a run, checked by a stop-order predictor or typed results
// depends on ets_pkg and the core rtl
module elevator_two_queue_scheduler_core_tb;
  import ets_pkg::*;

  localparam int FLOORS        = 64;
  localparam int QUEUE_DEPTH   = 16;
  localparam int PHASE_ITEMS   = 70;
  // longest insert walk spans about two full queues; a run walks both queues
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT   = 400000;

  // the one command code the package leaves unnamed, the core ignores it
  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef logic [FloorW-1:0] floor_t;

  // how a directed row is checked
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_TYPED,
    ROW_SILENT
  } row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    req_t      req;
    res_t      res;
  } step_row_t;

  logic   clk_i      = 1'b0;
  logic   rst_ni     = 1'b1;
  logic   start      = 1'b0;
  req_t   req_i      = '0;
  logic   cfg_we_i   = 1'b0;
  floor_t cfg_data_i = '0;
  logic   busy;
  logic   res_valid_o;
  res_t   res_o;

  // scheduler state as the predictor sees it: both queues kept sorted ascending
  floor_t up_stops[$];
  floor_t down_stops[$];
  floor_t car_floor_m = '0;

  // results still owed by the core, oldest first
  res_t      pending_results[$];
  // results of the request just taken
  res_t      fresh_results[$];
  step_row_t directed_rows[$];
  res_t      want_res;
  int        errors      = 0;
  int        cycle_count = 0;

  elevator_two_queue_scheduler_core #(
    .FLOORS     (FLOORS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_i      (req_i),
    .busy       (busy),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // floors past the top of the building count as the top floor
  function automatic floor_t sat_floor(input floor_t f);
    if (int'(f) >= FLOORS) return floor_t'(FLOORS - 1);
    return f;
  endfunction

  function automatic res_t make_res(input logic [1:0] st, input floor_t fl, input logic dp,
                                    input logic lst);
    res_t r;
    r.status    = st;
    r.floor     = fl;
    r.down_pass = dp;
    r.last      = lst;
    return r;
  endfunction

  // works out the results of one taken request and moves the scheduler state on
  function automatic void schedule_request(input req_t r);
    floor_t lane[$];
    floor_t from_f;
    floor_t to_f;
    floor_t swap;
    int     need;
    int     j;
    fresh_results.delete();
    from_f = sat_floor(r.from_floor);
    to_f   = sat_floor(r.to_floor);
    case (r.cmd)
      CMD_UP, CMD_DOWN: begin
        if (r.cmd == CMD_UP) lane = up_stops;
        else lane = down_stops;
        // a hall call needs room for the pickup floor too, or nothing is queued
        need = r.outside ? 2 : 1;
        if (lane.size() + need > QUEUE_DEPTH) begin
          fresh_results.push_back(make_res(RES_DROPPED, to_f, 1'b0, 1'b1));
        end else begin
          if (r.outside) lane.push_back(from_f);
          lane.push_back(to_f);
          // equal floors stay as separate entries, so order among them is moot
          for (int i = 1; i < lane.size(); i++) begin
            j = i;
            while (j > 0 && lane[j-1] > lane[j]) begin
              swap      = lane[j];
              lane[j]   = lane[j-1];
              lane[j-1] = swap;
              j--;
            end
          end
          if (r.cmd == CMD_UP) up_stops = lane;
          else down_stops = lane;
          fresh_results.push_back(make_res(RES_QUEUED, to_f, 1'b0, 1'b1));
        end
      end
      CMD_RUN: begin
        // up queue ascending, then down queue descending, then done at the car floor
        for (int i = 0; i < up_stops.size(); i++) begin
          car_floor_m = up_stops[i];
          fresh_results.push_back(make_res(RES_STOP, car_floor_m, 1'b0, 1'b0));
        end
        up_stops.delete();
        for (int i = down_stops.size() - 1; i >= 0; i--) begin
          car_floor_m = down_stops[i];
          fresh_results.push_back(make_res(RES_STOP, car_floor_m, 1'b1, 1'b0));
        end
        down_stops.delete();
        fresh_results.push_back(make_res(RES_DONE, car_floor_m, 1'b0, 1'b1));
      end
      default: ;
    endcase
  endfunction

  // one directed row; typed rows carry the single result expected from them
  function automatic void add_row(input row_kind_e kind, input logic [1:0] cmd,
                                  input floor_t from_f, input floor_t to_f, input logic hall,
                                  input logic [1:0] st);
    step_row_t row;
    row.kind           = kind;
    row.req.cmd        = cmd;
    row.req.from_floor = from_f;
    row.req.to_floor   = to_f;
    row.req.outside    = hall;
    row.res            = make_res(st, to_f, 1'b0, 1'b1);
    directed_rows.push_back(row);
  endfunction

  // offers one request after a random gap and returns at the edge that takes it;
  // start is left high, the next call or a drain decides its next value
  task automatic send_request(input req_t r, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
  endtask

  // sender holds off until every owed result is in, then gives the core time to go idle,
  // since an ignored command or an insert may still be in flight
  task automatic wait_until_drained;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // start floor write, only with the core idle; the car moves there at once
  task automatic write_start_floor(input floor_t f);
    wait_until_drained();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= f;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    car_floor_m = sat_floor(f);
  endtask

  // result checker: the receiver never stalls, every strobe is a result
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, actual %h", $time, res_o);
      end else begin
        want_res = pending_results.pop_front();
        if (res_o.status !== want_res.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want_res.status,
                   res_o.status);
        end
        if (res_o.floor !== want_res.floor) begin
          errors++;
          $display("%0t: floor expected %0d actual %0d", $time, want_res.floor, res_o.floor);
        end
        if (res_o.down_pass !== want_res.down_pass) begin
          errors++;
          $display("%0t: down_pass expected %0d actual %0d", $time, want_res.down_pass,
                   res_o.down_pass);
        end
        if (res_o.last !== want_res.last) begin
          errors++;
          $display("%0t: last expected %0d actual %0d", $time, want_res.last, res_o.last);
        end
      end
    end
  end

  // watchdog against a hung handshake or lost results
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    req_t      r;
    step_row_t row;
    int        taken;
    int        burst;
    floor_t    phase_floor[4];
    int        phase_idle[4];

    // reset goes active at time zero, before the first clock edge
    rst_ni <= 1'b0;
    // no gaps, sender mostly idle, no gaps again (receiver cannot stall), light gaps
    phase_idle = '{0, 81, 0, 31};

    // directed table, reset start floor of 0 still in force
    // run on empty queues: only the done result, at the reset floor
    add_row(ROW_TYPED,   CMD_RUN,  6'd0,  6'd0,  1'b0, RES_DONE);
    // unused command, nothing comes back
    add_row(ROW_SILENT,  CMD_NONE, 6'd63, 6'd63, 1'b1, RES_QUEUED);
    // floor extremes, cabin and hall calls
    add_row(ROW_TYPED,   CMD_UP,   6'd0,  6'd63, 1'b0, RES_QUEUED);
    add_row(ROW_TYPED,   CMD_UP,   6'd0,  6'd63, 1'b1, RES_QUEUED);
    add_row(ROW_TYPED,   CMD_UP,   6'd63, 6'd0,  1'b1, RES_QUEUED);
    // duplicate floors each keep their own stop
    add_row(ROW_TYPED,   CMD_UP,   6'd21, 6'd5,  1'b0, RES_QUEUED);
    add_row(ROW_TYPED,   CMD_UP,   6'd42, 6'd5,  1'b0, RES_QUEUED);
    add_row(ROW_TYPED,   CMD_DOWN, 6'd7,  6'd7,  1'b1, RES_QUEUED);
    add_row(ROW_TYPED,   CMD_DOWN, 6'd63, 6'd0,  1'b0, RES_QUEUED);
    add_row(ROW_TYPED,   CMD_DOWN, 6'd0,  6'd63, 1'b0, RES_QUEUED);
    add_row(ROW_PREDICT, CMD_RUN,  6'd0,  6'd0,  1'b0, RES_QUEUED);
    // fill the up queue to one free slot with hall calls
    add_row(ROW_PREDICT, CMD_UP,   6'd12, 6'd30, 1'b1, RES_QUEUED);
    add_row(ROW_PREDICT, CMD_UP,   6'd50, 6'd3,  1'b1, RES_QUEUED);
    add_row(ROW_PREDICT, CMD_UP,   6'd33, 6'd33, 1'b1, RES_QUEUED);
    add_row(ROW_PREDICT, CMD_UP,   6'd1,  6'd62, 1'b1, RES_QUEUED);
    add_row(ROW_PREDICT, CMD_UP,   6'd44, 6'd17, 1'b1, RES_QUEUED);
    add_row(ROW_PREDICT, CMD_UP,   6'd9,  6'd26, 1'b1, RES_QUEUED);
    add_row(ROW_PREDICT, CMD_UP,   6'd55, 6'd40, 1'b1, RES_QUEUED);
    add_row(ROW_PREDICT, CMD_UP,   6'd0,  6'd21, 1'b0, RES_QUEUED);
    // hall call with one free slot is dropped whole
    add_row(ROW_TYPED,   CMD_UP,   6'd11, 6'd22, 1'b1, RES_DROPPED);
    add_row(ROW_TYPED,   CMD_UP,   6'd0,  6'd14, 1'b0, RES_QUEUED);
    // full queue drops even a cabin call
    add_row(ROW_TYPED,   CMD_UP,   6'd0,  6'd60, 1'b0, RES_DROPPED);
    add_row(ROW_PREDICT, CMD_RUN,  6'd63, 6'd63, 1'b1, RES_QUEUED);

    phase_floor[0] = 6'd63;
    phase_floor[1] = 6'd0;
    phase_floor[2] = floor_t'($urandom_range(1, 62));
    phase_floor[3] = floor_t'($urandom_range(0, 63));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_request(row.req, 0);
      schedule_request(row.req);
      if (row.kind == ROW_PREDICT) begin
        foreach (fresh_results[k]) pending_results.push_back(fresh_results[k]);
      end else if (row.kind == ROW_TYPED) begin
        pending_results.push_back(row.res);
      end
    end

    // random part: bursts of floor calls closed by a run, with ignored commands as noise
    for (int phase = 0; phase < 4; phase++) begin
      write_start_floor(phase_floor[phase]);
      taken = 0;
      while (taken < PHASE_ITEMS) begin
        burst = $urandom_range(0, 24);
        for (int b = 0; b <= burst; b++) begin
          r.from_floor = floor_t'($urandom_range(0, 63));
          r.to_floor   = floor_t'($urandom_range(0, 63));
          r.outside    = 1'($urandom_range(0, 1));
          if (b == burst) r.cmd = CMD_RUN;
          else if ($urandom_range(19) == 0) r.cmd = CMD_NONE;
          else if ($urandom_range(1) == 0) r.cmd = CMD_UP;
          else r.cmd = CMD_DOWN;
          send_request(r, phase_idle[phase]);
          schedule_request(r);
          foreach (fresh_results[k]) pending_results.push_back(fresh_results[k]);
          if (r.cmd != CMD_NONE) taken++;
        end
      end
    end

    wait_until_drained();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/ets_pkg.sv
src/elevator_two_queue_scheduler_core.sv
verif/elevator_two_queue_scheduler_core_tb.sv
